@@ rtl/ptms_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptms_pkg
// Shared types, codes and helpers of the per-pixel temporal mean / deviation
// block.
// ============================================================================
package ptms_pkg;

    // transaction payloads
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_value;
        logic [9:0]  query_x;
        logic [9:0]  query_y;
    } ptms_in_t;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] deviation_tenths;
        logic        value_valid;
        logic        deviation_valid;
        logic        frame_done;
    } ptms_out_t;

    // input kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_FRAMES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_FRAMES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd4;

    // datapath widths
    localparam int SUM_W  = 25;
    localparam int SQ_W   = 40;
    localparam int DIV_W  = 32;
    localparam int DSR_W  = 9;
    localparam int RAD_W  = 62;
    localparam int ROOT_W = 31;
    localparam int LIM_W  = 13;

    typedef logic [LIM_W-1:0] lim_t;

    // rounding constants
    localparam int ROUND_HALF = 5;
    localparam int DEV_SCALE  = 10000;

    // x / 10 == (x * TENTH_RECIP) >> TENTH_SHIFT, exact for any 32-bit x
    localparam logic [31:0] TENTH_RECIP = 32'hCCCC_CCCD;
    localparam int          TENTH_SHIFT = 35;

    // frame size register: 0 counts as 1, large values clip to the maximum
    function automatic lim_t clamp_size(input logic [CFG_DATA_W-1:0] v, input lim_t max_v);
        lim_t v_ext;
        v_ext = lim_t'(v);
        if (v_ext == lim_t'(0)) begin
            return lim_t'(1);
        end
        return (v_ext > max_v) ? max_v : v_ext;
    endfunction

    function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
        return (v[DIV_W-1:16] != '0) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

@@ rtl/ptms_divider.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptms_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ============================================================================
module ptms_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ptms_pkg::DIV_W-1:0]  dividend,
    input  logic [ptms_pkg::DSR_W-1:0]  divisor,
    output logic                        done,
    output logic [ptms_pkg::DIV_W-1:0]  quotient
);
    localparam int CNT_W = $clog2(ptms_pkg::DIV_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [ptms_pkg::DIV_W-1:0] dq_reg;
    logic [ptms_pkg::DSR_W-1:0] rem_reg;
    logic [ptms_pkg::DSR_W-1:0] dsr_reg;

    logic [ptms_pkg::DSR_W:0]   rem_sh;
    logic                       ge;
    logic [ptms_pkg::DSR_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[ptms_pkg::DIV_W-1]};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_next = ge ? ptms_pkg::DSR_W'(rem_sh - {1'b0, dsr_reg})
                      : rem_sh[ptms_pkg::DSR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ptms_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[ptms_pkg::DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

@@ rtl/ptms_isqrt.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptms_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ============================================================================
module ptms_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ptms_pkg::RAD_W-1:0]   radicand,
    output logic                         done,
    output logic [ptms_pkg::ROOT_W-1:0]  root
);
    localparam int CNT_W = $clog2(ptms_pkg::ROOT_W);
    localparam int REM_W = ptms_pkg::ROOT_W + 2;

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [ptms_pkg::RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [ptms_pkg::ROOT_W-1:0] root_reg;

    logic [REM_W+1:0]            rem_sh;
    logic [REM_W+1:0]            trial;
    logic                        ge;
    logic [REM_W-1:0]            rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[ptms_pkg::RAD_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        ge       = rem_sh >= trial;
        rem_next = ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ptms_pkg::ROOT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[ptms_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[ptms_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/pixel_temporal_mean_and_stddev.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pixel_temporal_mean_and_stddev
// Per-pixel temporal mean and standard deviation over a raster pixel stream.
// ============================================================================
// Pixels stream in raster order; each position keeps a running sum and sum of
// squares in one on-chip memory (entry = {row, column}). In average mode every
// average_frames frames the truncated mean is stored and returned; in snapshot
// mode the last of snapshot_frames frames returns the rounded mean and the
// deviation in tenths. Queries read back the stored value. Every input
// transaction returns exactly one output transaction. One item is in work at a
// time, set by the memory read-modify-write and the shared iterative units:
// a pixel that closes no group, a query and a restart pass only through the
// read-modify-write and output states; a pixel that closes an average adds
// one 32-step division; the last snapshot frame adds two 32-step divisions,
// a 31-step square root, four multiply stages and two reciprocal multiplies
// for the divisions by ten. After reset the stored-value memory is cleared
// one entry a cycle, all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries
// (65536 at the defaults); in_ready stays low until then, configuration
// writes are taken throughout. The output register decouples the result side:
// a new item is accepted while the previous result still waits for out_ready.
// ============================================================================
module pixel_temporal_mean_and_stddev #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptms_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ptms_pkg::ptms_in_t                  in_data,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output ptms_pkg::ptms_out_t                 out_data
);
    localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;

    localparam int SUM_W = ptms_pkg::SUM_W;
    localparam int SQ_W  = ptms_pkg::SQ_W;

    // sequencer states
    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_RMW   = 11'b000_0000_0100,
        ST_DIV   = 11'b000_0000_1000,
        ST_MULA  = 11'b000_0001_0000,
        ST_MULB  = 11'b000_0010_0000,
        ST_MULC  = 11'b000_0100_0000,
        ST_MULD  = 11'b000_1000_0000,
        ST_SQRT  = 11'b001_0000_0000,
        ST_OUT   = 11'b010_0000_0000,
        ST_TEN   = 11'b100_0000_0000
    } state_t;

    // which quotient the shared divider / divide-by-ten step is working on
    typedef enum logic [2:0] {
        DS_AVG  = 3'b001,
        DS_MEAN = 3'b010,
        DS_DEV  = 3'b100
    } sel_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_QUERY,
        OP_AVG,
        OP_SNAP
    } op_t;

    // ---------------------------------------------------------------- config
    logic                               mode_reg;
    logic [8:0]                         avg_reg;
    logic [7:0]                         snap_reg;
    logic [ptms_pkg::CFG_DATA_W-1:0]    fw_reg;
    logic [ptms_pkg::CFG_DATA_W-1:0]    fh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            avg_reg  <= 9'd1;
            snap_reg <= 8'd1;
            fw_reg   <= 9'd256;
            fh_reg   <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ptms_pkg::CFG_MODE:        mode_reg <= cfg_data[0];
                ptms_pkg::CFG_AVG_FRAMES:  avg_reg  <= cfg_data;
                ptms_pkg::CFG_SNAP_FRAMES: snap_reg <= cfg_data[7:0];
                ptms_pkg::CFG_WIDTH:       fw_reg   <= cfg_data;
                ptms_pkg::CFG_HEIGHT:      fh_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- frame position
    state_t             state_reg, state_next;
    sel_t               sel_reg, sel_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [8:0]         fc_reg;
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;

    logic               in_fire;
    ptms_pkg::lim_t     w_lim, h_lim;
    logic               last_col, last_pix;
    logic [9:0]         fc_plus;
    logic [8:0]         avg_n;
    logic               avg_comp, snap_act, snap_comp, q_in;
    op_t                op_next;
    logic [CW-1:0]      qx_a;
    logic [RW-1:0]      qy_a;
    logic [AW-1:0]      rd_addr;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        w_lim     = ptms_pkg::clamp_size(fw_reg, ptms_pkg::lim_t'(MAX_WIDTH));
        h_lim     = ptms_pkg::clamp_size(fh_reg, ptms_pkg::lim_t'(MAX_HEIGHT));
        last_col  = (ptms_pkg::lim_t'(col_reg) + ptms_pkg::lim_t'(1)) >= w_lim;
        last_pix  = last_col && ((ptms_pkg::lim_t'(row_reg) + ptms_pkg::lim_t'(1)) >= h_lim);
        fc_plus   = {1'b0, fc_reg} + 10'd1;
        avg_n     = (avg_reg == 9'd0) ? 9'd1 : avg_reg;
        avg_comp  = fc_plus >= {1'b0, avg_n};
        snap_act  = fc_reg < {1'b0, snap_reg};
        snap_comp = fc_plus == {2'b00, snap_reg};
        q_in      = (ptms_pkg::lim_t'(in_data.query_x) < w_lim) &&
                    (ptms_pkg::lim_t'(in_data.query_y) < h_lim);
        qx_a      = CW'(in_data.query_x);
        qy_a      = RW'(in_data.query_y);

        case (in_data.kind)
            ptms_pkg::KIND_PIXEL: op_next = mode_reg ? (snap_act ? OP_SNAP : OP_NONE) : OP_AVG;
            ptms_pkg::KIND_QUERY: op_next = OP_QUERY;
            default:              op_next = OP_NONE;
        endcase

        rd_addr = (in_data.kind == ptms_pkg::KIND_QUERY) ? {qy_a, qx_a} : {row_reg, col_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (in_data.kind == ptms_pkg::KIND_RESTART)
            begin
                fc_reg  <= '0;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (in_data.kind == ptms_pkg::KIND_PIXEL)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_pix ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
                // frame counter moves on the last pixel of a frame
                if (last_pix)
                begin
                    if (!mode_reg)
                    begin
                        fc_reg <= avg_comp ? '0 : fc_plus[8:0];
                    end
                    else if (snap_act)
                    begin
                        fc_reg <= fc_plus[8:0];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------- captured item
    op_t                op_reg;
    logic [15:0]        pix_reg;
    logic               first_reg, comp_reg, done_reg, inrange_reg;
    logic [8:0]         n_reg;
    logic [AW-1:0]      addr_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= op_next;
            pix_reg     <= in_data.pixel_value;
            first_reg   <= (fc_reg == 9'd0);
            comp_reg    <= mode_reg ? snap_comp : avg_comp;
            done_reg    <= last_pix && (mode_reg ? snap_comp : avg_comp);
            n_reg       <= mode_reg ? {1'b0, snap_reg} : avg_n;
            addr_reg    <= rd_addr;
            inrange_reg <= q_in;
        end
    end

    // ------------------------------------------------------------ memories
    // sum and sum of squares share one entry; average mode writes the square
    // half back as it was read
    logic [SQ_W+SUM_W-1:0]  acc_mem [DEPTH];
    logic [15:0]            sv_mem  [DEPTH];

    logic [SUM_W-1:0]   rs_reg;
    logic [SQ_W-1:0]    rsq_reg;
    logic [15:0]        rsv_reg;

    logic               sum_we, sq_we, sv_we;
    logic [AW-1:0]      sv_waddr;
    logic [15:0]        sv_wdata;
    logic [SUM_W-1:0]   sum_in;
    logic [SQ_W-1:0]    sq_in;
    logic [31:0]        pix_sq;

    // first frame of a group overwrites, later frames accumulate (wrapping)
    always_comb
    begin
        pix_sq = pix_reg * pix_reg;
        sum_in = first_reg ? SUM_W'(pix_reg) : rs_reg + SUM_W'(pix_reg);
        sq_in  = first_reg ? SQ_W'(pix_sq)   : rsq_reg + SQ_W'(pix_sq);
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            acc_mem[addr_reg] <= {(sq_we ? sq_in : rsq_reg), sum_in};
        end
        if (in_fire)
        begin
            {rsq_reg, rs_reg} <= acc_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
        begin
            sv_mem[sv_waddr] <= sv_wdata;
        end
        if (in_fire)
        begin
            rsv_reg <= sv_mem[rd_addr];
        end
    end

    // ----------------------------------------------------- arithmetic units
    logic                           div_start, div_done;
    logic [ptms_pkg::DIV_W-1:0]     div_dvd, div_quo;
    logic [ptms_pkg::DSR_W-1:0]     div_dsr;
    logic                           sqrt_start, sqrt_done;
    logic [ptms_pkg::RAD_W-1:0]     sqrt_rad;
    logic [ptms_pkg::ROOT_W-1:0]    sqrt_root;

    ptms_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    ptms_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // variance chain: D = N*S2 - S1^2 (0 if negative), then 10000*D
    logic [SUM_W-1:0]   s1_reg;
    logic [SQ_W-1:0]    s2_reg;
    logic [27:0]        a_lo_reg, a_hi_reg;
    logic [49:0]        b_reg;
    logic [47:0]        d_reg;
    logic [37:0]        p_lo_reg, p_hi_reg;
    logic [47:0]        a_full;

    always_comb
    begin
        a_full   = {a_hi_reg, 20'b0} + 48'(a_lo_reg);
        sqrt_rad = {p_hi_reg, 24'b0} + ptms_pkg::RAD_W'(p_lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RMW)
        begin
            s1_reg <= sum_in;
            s2_reg <= sq_in;
        end
        a_lo_reg <= n_reg[7:0] * s2_reg[19:0];
        a_hi_reg <= n_reg[7:0] * s2_reg[39:20];
        b_reg    <= s1_reg * s1_reg;
        d_reg    <= ({2'b00, a_full} > b_reg) ? 48'({2'b00, a_full} - b_reg) : '0;
        p_lo_reg <= d_reg[23:0]  * 14'(ptms_pkg::DEV_SCALE);
        p_hi_reg <= d_reg[47:24] * 14'(ptms_pkg::DEV_SCALE);
    end

    // rounded divide by ten: (q + 5) / 10 by reciprocal multiplication
    logic [31:0]            ten_reg, ten_next;
    logic [63:0]            ten_prod;
    logic [15:0]            ten_q;

    always_comb
    begin
        ten_prod = ten_reg * ptms_pkg::TENTH_RECIP;
        ten_q    = ptms_pkg::sat16(ptms_pkg::DIV_W'(ten_prod[63:ptms_pkg::TENTH_SHIFT]));
    end

    // ----------------------------------------------------------- sequencer
    ptms_pkg::ptms_out_t    res_reg, res_next;
    logic [15:0]            mean_reg, mean_next;
    logic                   load_out;
    logic                   out_valid_reg;
    ptms_pkg::ptms_out_t    out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        mean_next  = mean_reg;
        ten_next   = ten_reg;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dsr    = '0;
        sqrt_start = 1'b0;
        sum_we     = 1'b0;
        sq_we      = 1'b0;
        sv_we      = 1'b0;
        sv_waddr   = addr_reg;
        sv_wdata   = '0;
        load_out   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                sv_we    = 1'b1;
                sv_waddr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                res_next   = '0;
                state_next = ST_OUT;
                case (op_reg)
                    OP_QUERY:
                    begin
                        res_next.value       = inrange_reg ? rsv_reg : 16'd0;
                        res_next.value_valid = 1'b1;
                    end
                    OP_AVG:
                    begin
                        sum_we = 1'b1;
                        if (comp_reg)
                        begin
                            div_start  = 1'b1;
                            div_dvd    = ptms_pkg::DIV_W'(sum_in);
                            div_dsr    = n_reg;
                            sel_next   = DS_AVG;
                            state_next = ST_DIV;
                        end
                    end
                    OP_SNAP:
                    begin
                        sum_we = 1'b1;
                        sq_we  = 1'b1;
                        // first snapshot frame keeps the raw pixel
                        if (first_reg)
                        begin
                            sv_we    = 1'b1;
                            sv_wdata = pix_reg;
                        end
                        if (comp_reg)
                        begin
                            div_start  = 1'b1;
                            div_dvd    = ptms_pkg::DIV_W'({sum_in, 3'b000}) +
                                         ptms_pkg::DIV_W'({sum_in, 1'b0});
                            div_dsr    = n_reg;
                            sel_next   = DS_MEAN;
                            state_next = ST_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        DS_AVG:
                        begin
                            res_next.value       = ptms_pkg::sat16(div_quo);
                            res_next.value_valid = 1'b1;
                            res_next.frame_done  = done_reg;
                            sv_we                = 1'b1;
                            sv_wdata             = ptms_pkg::sat16(div_quo);
                            state_next           = ST_OUT;
                        end
                        DS_MEAN, DS_DEV:
                        begin
                            ten_next   = div_quo + ptms_pkg::DIV_W'(ptms_pkg::ROUND_HALF);
                            state_next = ST_TEN;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_TEN:
            begin
                case (sel_reg)
                    DS_MEAN:
                    begin
                        mean_next  = ten_q;
                        state_next = ST_MULA;
                    end
                    DS_DEV:
                    begin
                        res_next.value            = mean_reg;
                        res_next.deviation_tenths = ten_q;
                        res_next.value_valid      = 1'b1;
                        res_next.deviation_valid  = 1'b1;
                        res_next.frame_done       = done_reg;
                        sv_we                     = 1'b1;
                        sv_wdata                  = mean_reg;
                        state_next                = ST_OUT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_MULA: state_next = ST_MULB;
            ST_MULB: state_next = ST_MULC;
            ST_MULC: state_next = ST_MULD;
            ST_MULD:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start  = 1'b1;
                    div_dvd    = ptms_pkg::DIV_W'(sqrt_root);
                    div_dsr    = n_reg;
                    sel_next   = DS_DEV;
                    state_next = ST_DIV;
                end
            end
            ST_OUT:
            begin
                // hand off once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sel_reg   <= DS_AVG;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        mean_reg <= mean_next;
        ten_reg  <= ten_next;
    end

    // ------------------------------------------------------ output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/ptms_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptms_checker
// Port-level checks of the temporal mean / deviation block.
// ============================================================================
module ptms_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [ptms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [ptms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             in_valid,
    input logic                             in_ready,
    input ptms_pkg::ptms_in_t               in_data,
    input logic                             out_valid,
    input logic                             out_ready,
    input ptms_pkg::ptms_out_t              out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

    // deviation only comes with a mean
    a_dev_with_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.deviation_valid |-> out_data.value_valid)
        else $error("deviation without value");

    // a result without a value is all zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.value_valid |->
            out_data.value == 16'd0 && out_data.deviation_tenths == 16'd0 &&
            !out_data.frame_done && !out_data.deviation_valid)
        else $error("empty result carries data");

endmodule

bind pixel_temporal_mean_and_stddev ptms_checker u_ptms_checker (.*);
